[rtl/mlfo_pkg.sv]
// shared constants and types for the morphing lfo
package mlfo_pkg;

  localparam int unsigned PhaseBitsDef = 32;
  localparam int unsigned SineBitsDef  = 10;
  localparam int unsigned LevelBitsDef = 16;

  localparam int unsigned SrBits   = 18;
  localparam logic [SrBits-1:0] SrReset = 18'd48000;

  // fixed-point shape format, 1.0 = 2^28
  localparam int unsigned FracBits = 28;
  localparam int unsigned RomBits  = 29;

  // divisor width of the shared divider
  localparam int unsigned DivsBits = 22;

  // morph breakpoints scaled by 100
  localparam logic [22:0] MorphEnd0 = 23'(33 * 65535);
  localparam logic [22:0] MorphLo1  = 23'(34 * 65535);
  localparam logic [22:0] MorphEnd1 = 23'(66 * 65535);
  localparam logic [22:0] MorphLo2  = 23'(67 * 65535);
  localparam logic [DivsBits-1:0] Span0 = DivsBits'(33 * 65535);
  localparam logic [DivsBits-1:0] Span1 = DivsBits'(32 * 65535);
  localparam logic [DivsBits-1:0] Span2 = DivsBits'(33 * 65535);

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/mlfo_if.sv]
// channel interfaces: configuration, input items, result items
interface mlfo_cfg_if;
  import mlfo_pkg::*;
  logic              valid;
  logic              ready;
  logic [SrBits-1:0] sample_rate;
  modport source (output valid, output sample_rate, input ready);
  modport sink (input valid, input sample_rate, output ready);
endinterface

interface mlfo_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] frequency;
  logic [15:0] window_start;
  logic [15:0] window_end;
  logic [15:0] morph;
  logic        restart;
  modport source (output valid, output frequency, output window_start, output window_end,
                  output morph, output restart, input ready);
  modport sink (input valid, input frequency, input window_start, input window_end,
                input morph, input restart, output ready);
endinterface

interface mlfo_out_if #(
  parameter int unsigned LEVEL_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [LEVEL_BITS-1:0] level;
  logic [31:0]                  phase_out;
  modport source (output valid, output level, output phase_out, input ready);
  modport sink (input valid, input level, input phase_out, output ready);
endinterface

[rtl/mlfo_div.sv]
// shared restoring divider, one quotient bit per cycle
module mlfo_div #(
  parameter int unsigned DVW = 50
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DVW-1:0]                dividend_i,
  input  logic [mlfo_pkg::DivsBits-1:0] divisor_i,
  output logic [DVW-1:0]                quotient_o,
  output mlfo_pkg::div_stat_t           stat_o
);
  import mlfo_pkg::*;

  localparam int unsigned CntW = $clog2(DVW + 1);

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [DVW-1:0]      dvd_q, dvd_d;
  logic [DivsBits-1:0] rem_q, rem_d;
  logic [DivsBits-1:0] dvs_q, dvs_d;
  logic [DivsBits:0]   trial;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, dvd_q[DVW-1]};
    if (start_i && cnt_q == '0) begin
      cnt_d = CntW'(DVW);
      dvd_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DivsBits'(trial - {1'b0, dvs_q});
        dvd_d = {dvd_q[DVW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivsBits-1:0];
        dvd_d = {dvd_q[DVW-2:0], 1'b0};
      end
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = dvd_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

[rtl/mlfo_sine_rom.sv]
// quarter-wave sine rom with registered read
module mlfo_sine_rom #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                               clk_i,
  input  logic [SINE_TABLE_BITS:0]           addr_i,
  output logic [mlfo_pkg::RomBits-1:0]       data_o
);
  import mlfo_pkg::*;

  localparam int unsigned Depth = (1 << SINE_TABLE_BITS) + 1;
  localparam logic [63:0] HalfPiQ28 = 64'd421657428;

  typedef logic [RomBits-1:0] rom_arr_t [Depth];

  // odd taylor series to x^13 in q28, truncating steps
  function automatic logic [RomBits-1:0] series_sine(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    x2   = (x * x) >> FracBits;
    term = x;
    pos  = x;
    neg  = '0;
    for (int k = 1; k <= 6; k++) begin
      term = (term * x2) >> FracBits;
      case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    if (neg >= pos) return '0;
    pos = pos - neg;
    if (pos > (64'd1 << FracBits)) pos = 64'd1 << FracBits;
    return pos[RomBits-1:0];
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int i = 0; i < Depth; i++) begin
      r[i] = series_sine((HalfPiQ28 * 64'(i)) >> SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_arr_t Rom = build_rom();

  logic [RomBits-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    rd_q <= Rom[addr_i];
  end

  assign data_o = rd_q;

endmodule

[rtl/morphing_lfo_with_phase_window.sv]
// morphing lfo top level: phase window, shared divider, blend sequencer
//
//  channel   dir   payload                                          handshake
//  cfg_i     in    sample_rate                                      valid/ready
//  in_i      in    frequency, window_start, window_end, morph,      valid/ready
//                  restart
//  out_o     out   level, phase_out                                 valid/ready
//
// the shared bit-serial divider, DVW = max(PHASE_BITS+16, 50) bits wide, runs twice
// per transaction (phase step, then fade factor). in_i is ready only while idle. a
// result waits in the output register until taken. reset clears the phase to zero
// and the sample rate to 48000; no clearing pass is needed.
module morphing_lfo_with_phase_window #(
  parameter int unsigned PHASE_BITS      = mlfo_pkg::PhaseBitsDef,
  parameter int unsigned SINE_TABLE_BITS = mlfo_pkg::SineBitsDef,
  parameter int unsigned LEVEL_BITS      = mlfo_pkg::LevelBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mlfo_cfg_if.sink         cfg_i,
  mlfo_in_if.sink          in_i,
  mlfo_out_if.source       out_o
);
  import mlfo_pkg::*;

  localparam int unsigned P   = PHASE_BITS;
  localparam int unsigned DVW = (P + 16 > 50) ? P + 16 : 50;
  localparam int unsigned NRep = (P + 15) / 16;
  localparam int unsigned PW  = 2 * FracBits + 6;
  localparam int unsigned LW  = 32 + LEVEL_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVP = 3'd1;
  localparam logic [2:0] ST_DIVR = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;
  localparam logic signed [LEVEL_BITS-1:0] FullScale =
    LEVEL_BITS'((64'd1 << (LEVEL_BITS - 1)) - 64'd1);

  logic [2:0]        state_q, state_d;
  logic [SrBits-1:0] sr_q;
  logic [P-1:0]      phase_q;
  logic [15:0]       ws_q, we_q, morph_q;
  logic              rst_q;
  logic [28:0]       t_q;
  logic signed [PW-1:0] prod1_q;
  logic signed [LW-1:0] prod2_q;
  logic signed [LEVEL_BITS-1:0] level_q;

  // configuration write
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= SrReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      sr_q <= cfg_i.sample_rate;
    end
  end

  // shared divider request
  logic                div_start;
  logic [DVW-1:0]      div_dvd;
  logic [DivsBits-1:0] div_dvs;
  logic [DVW-1:0]      div_quo;
  div_stat_t           div_stat;

  mlfo_div #(.DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  // window points as fractions of a turn
  logic [NRep*16-1:0] ws_rep, we_rep;
  logic [P:0] start_pt, end_frac, end_pt, sum, ph_full;
  logic [P-1:0] ph_new;
  assign ws_rep   = {NRep{ws_q}};
  assign we_rep   = {NRep{we_q}};
  assign start_pt = (ws_q == 16'hFFFF) ? {1'b1, {P{1'b0}}} : {1'b0, ws_rep[NRep*16-1 -: P]};
  assign end_frac = (we_q == 16'hFFFF) ? {1'b1, {P{1'b0}}} : {1'b0, we_rep[NRep*16-1 -: P]};
  assign end_pt   = {1'b1, {P{1'b0}}} - end_frac;
  assign sum      = {1'b0, phase_q} + {1'b0, div_quo[P-1:0]};

  // phase advance with window wrap
  always_comb begin
    if (sum > end_pt) ph_full = start_pt + sum - end_pt;
    else ph_full = sum;
    if (rst_q) ph_full = start_pt;
  end
  assign ph_new = ph_full[P-1:0];

  // top 32 bits of the phase
  logic [31:0] u;
  if (P >= 32) begin : g_top_wide
    assign u = phase_q[P-1 -: 32];
  end else begin : g_top_narrow
    assign u = {phase_q, {(32 - P){1'b0}}};
  end

  // sine lookup
  logic [SINE_TABLE_BITS:0] rom_addr, idx;
  logic [RomBits-1:0]       rom_data;
  assign idx      = {1'b0, u[29 -: SINE_TABLE_BITS]};
  assign rom_addr = u[30] ? (SINE_TABLE_BITS + 1)'(1 << SINE_TABLE_BITS) - idx : idx;

  mlfo_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // shapes in q28
  logic signed [31:0] x, sine, tri_w, saw, sq;
  assign x    = {3'b000, u[31:3]};
  assign sine = u[31] ? -$signed({3'b000, rom_data}) : $signed({3'b000, rom_data});
  always_comb begin
    if (x <= (One >>> 1)) tri_w = 2 * x;
    else if (x >= 3 * (One >>> 1)) tri_w = 2 * x - 4 * One;
    else tri_w = 2 * One - 2 * x;
    saw = (x <= One) ? x : x - 2 * One;
    sq  = (x < One) ? One : -One;
  end

  // morph region and fade endpoints
  logic [22:0] m100, lo;
  logic [DivsBits-1:0] span;
  logic signed [31:0] fa, fb;
  always_comb begin
    m100 = 23'(morph_q) * 23'd100;
    if (m100 <= MorphEnd0) begin
      fa = sine; fb = tri_w; lo = '0; span = Span0;
    end else if (m100 <= MorphEnd1) begin
      fa = tri_w; fb = saw; lo = MorphLo1; span = Span1;
    end else begin
      fa = saw; fb = sq; lo = MorphLo2; span = Span2;
    end
  end

  logic [22:0] mdiff;
  assign mdiff = (m100 > lo) ? m100 - lo : '0;

  // divider operands by state
  always_comb begin
    div_start = 1'b0;
    div_dvd   = DVW'({in_i.frequency, {(P - 8){1'b0}}});
    div_dvs   = (sr_q == '0) ? DivsBits'(1) : DivsBits'(sr_q);
    if (state_q == ST_IDLE) begin
      div_start = in_i.valid;
    end else if (state_q == ST_DIVP && div_stat.done) begin
      div_start = 1'b1;
      div_dvd   = DVW'({mdiff[DivsBits-1:0], {FracBits{1'b0}}});
      div_dvs   = span;
    end
  end

  // fade multiply and level scaling
  logic signed [PW-1:0] adj1;
  logic signed [31:0]   blend;
  logic signed [LW-1:0] adj2;
  assign adj1  = prod1_q + (prod1_q < 0 ? PW'((64'd1 << FracBits) - 64'd1) : PW'(0));
  assign blend = fa + 32'(adj1 >>> FracBits);
  assign adj2  = prod2_q + (prod2_q < 0 ? LW'((64'd1 << FracBits) - 64'd1) : LW'(0));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_DIVP;
      ST_DIVP: if (div_stat.done) state_d = ST_DIVR;
      ST_DIVR: if (div_stat.done) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_OUT;
      ST_OUT:  if (out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIVP && div_stat.done) phase_q <= ph_new;
    end
  end

  // item fields and datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      ws_q    <= in_i.window_start;
      we_q    <= in_i.window_end;
      morph_q <= in_i.morph;
      rst_q   <= in_i.restart;
    end
    if (state_q == ST_DIVR && div_stat.done) begin
      t_q <= (div_quo > DVW'(1 << FracBits)) ? 29'(1 << FracBits) : div_quo[28:0];
    end
    if (state_q == ST_MUL1) prod1_q <= PW'(fb - fa) * PW'($signed({1'b0, t_q}));
    if (state_q == ST_MUL2) prod2_q <= LW'(blend) * LW'(FullScale);
  end

  assign level_q = LEVEL_BITS'(adj2 >>> FracBits);

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = (state_q == ST_OUT);
  assign out_o.level     = level_q;
  assign out_o.phase_out = u;

endmodule

[rtl/mlfo_checker.sv]
// port-level checks for the morphing lfo, bound to the top level
module mlfo_checker #(
  parameter int unsigned LEVEL_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_BITS-1:0] level,
  input logic [31:0]           phase_out
);

  // a waiting result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(phase_out))
    else $error("stalled result changed");

  // an accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after transaction");

  // never taking input while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input ready with result pending");

  // a delivered result returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("block not idle after result transaction");

endmodule

bind morphing_lfo_with_phase_window mlfo_checker #(.LEVEL_BITS(LEVEL_BITS)) u_mlfo_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .level     (out_o.level),
  .phase_out (out_o.phase_out)
);

[tb/testbench.sv]
// testbench for the morphing lfo: directed, config sweep, random and backpressure tests
module testbench;
  import mlfo_pkg::*;

  localparam longint unsigned Turn    = 64'd1 << 32;
  localparam longint unsigned PhMask  = Turn - 1;
  localparam longint          OneQ28  = 64'sd1 << 28;
  localparam longint          FullScl = 32767;
  localparam int unsigned     QtrN    = 1024;
  localparam int unsigned     Latency = 150;

  typedef struct packed {
    logic signed [15:0] level;
    logic [31:0]        phase;
  } lfo_result_t;

  typedef struct packed {
    logic [23:0] frequency;
    logic [15:0] window_start;
    logic [15:0] window_end;
    logic [15:0] morph;
    logic        restart;
  } lfo_item_t;

  logic clk_i;
  logic rst_ni;

  mlfo_cfg_if cfg_ch ();
  mlfo_in_if  item_ch ();
  mlfo_out_if #(.LEVEL_BITS(16)) res_ch ();

  morphing_lfo_with_phase_window dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (item_ch),
    .out_o  (res_ch)
  );

  // predictor state
  longint unsigned quarter_sine [QtrN+1];
  longint unsigned model_phase;
  longint unsigned model_rate;
  lfo_result_t     pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int mismatches;
  bit failed;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #15000000;
    $display("status: fail");
    $finish;
  end

  // truncating taylor sine in q28, as the rom is built
  function automatic longint unsigned taylor_sine(longint unsigned x);
    longint unsigned x2, term, pos, neg, k;
    x2 = (x * x) >> 28;
    term = x;
    pos = x;
    neg = 0;
    for (k = 1; k <= 6; k++) begin
      term = (term * x2) >> 28;
      term = term / ((2 * k) * (2 * k + 1));
      if (k & 1) neg += term;
      else pos += term;
    end
    if (neg >= pos) return 0;
    pos -= neg;
    if (pos > OneQ28) pos = OneQ28;
    return pos;
  endfunction

  function automatic longint unsigned turn_fraction(longint unsigned v);
    return v * (Turn / 65535) + (v * (Turn % 65535)) / 65535;
  endfunction

  function automatic longint sine_at(logic [31:0] u);
    logic [1:0] quad;
    int unsigned idx;
    longint v;
    quad = u[31:30];
    idx = u[29:20];
    if (quad[0]) idx = QtrN - idx;
    v = longint'(quarter_sine[idx]);
    return quad[1] ? -v : v;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + ((b - a) * t) / OneQ28;
  endfunction

  function automatic longint fade_factor(longint unsigned m100, longint unsigned lo,
                                         longint unsigned span);
    longint unsigned t;
    if (m100 <= lo) return 0;
    t = ((m100 - lo) << 28) / span;
    if (t > OneQ28) t = OneQ28;
    return longint'(t);
  endfunction

  function automatic longint morph_shape(logic [15:0] m, logic [31:0] u);
    longint x, tri_v, saw_v, sq_v;
    longint unsigned m100;
    x = longint'(u >> 3);
    m100 = longint'(m) * 100;
    if (x <= OneQ28 / 2) tri_v = 2 * x;
    else if (x >= 3 * OneQ28 / 2) tri_v = 2 * x - 4 * OneQ28;
    else tri_v = 2 * OneQ28 - 2 * x;
    saw_v = (x <= OneQ28) ? x : x - 2 * OneQ28;
    sq_v = (x < OneQ28) ? OneQ28 : -OneQ28;
    if (m100 <= 33 * 65535)
      return blend(sine_at(u), tri_v, fade_factor(m100, 0, 33 * 65535));
    if (m100 <= 66 * 65535)
      return blend(tri_v, saw_v, fade_factor(m100, 34 * 65535, 32 * 65535));
    return blend(saw_v, sq_v, fade_factor(m100, 67 * 65535, 33 * 65535));
  endfunction

  // advance the phase and predict one result
  function automatic lfo_result_t lfo_predict(lfo_item_t it);
    longint unsigned start_pt, end_pt, sr, q, r, step, sum, ph;
    longint lvl;
    lfo_result_t res;
    start_pt = turn_fraction(it.window_start);
    end_pt = Turn - turn_fraction(it.window_end);
    sr = (model_rate != 0) ? model_rate : 1;
    q = it.frequency / sr;
    r = it.frequency % sr;
    step = ((q << 24) + ((r << 24) / sr)) & PhMask;
    sum = model_phase + step;
    ph = (sum > end_pt) ? start_pt + (sum - end_pt) : sum;
    if (it.restart) ph = start_pt;
    ph &= PhMask;
    model_phase = ph;
    lvl = (morph_shape(it.morph, ph[31:0]) * FullScl) / OneQ28;
    res.level = lvl[15:0];
    res.phase = ph[31:0];
    return res;
  endfunction

  // result side: random ready, long hold-off, checking
  always @(posedge clk_i) begin
    lfo_result_t exp_res;
    if (res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: level %0d phase %h",
                                       res_ch.level, res_ch.phase_out);
      end else begin
        exp_res = pending_results.pop_front();
        if (res_ch.level !== exp_res.level || res_ch.phase_out !== exp_res.phase) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: level exp %0d got %0d, phase exp %h got %h",
                     exp_res.level, res_ch.level, exp_res.phase, res_ch.phase_out);
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one input transaction; valid stays high afterwards unless the next call idles or drain() follows
  task automatic send_item(lfo_item_t it);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 5);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid        <= 1'b1;
    item_ch.frequency    <= it.frequency;
    item_ch.window_start <= it.window_start;
    item_ch.window_end   <= it.window_end;
    item_ch.morph        <= it.morph;
    item_ch.restart      <= it.restart;
    do @(posedge clk_i); while (!item_ch.ready);
    pending_results.push_back(lfo_predict(it));
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_sample_rate(logic [SrBits-1:0] rate);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.sample_rate <= rate;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    model_rate = rate;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic lfo_item_t random_item();
    lfo_item_t it;
    it.frequency = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40000));
    it.window_start = pick16();
    it.window_end = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 20000)) : pick16();
    it.morph = pick16();
    it.restart = ($urandom_range(9) == 0);
    return it;
  endfunction

  function automatic lfo_item_t make_item(logic [23:0] f, logic [15:0] ws, logic [15:0] we,
                                          logic [15:0] m, logic rs);
    lfo_item_t it;
    it.frequency = f;
    it.window_start = ws;
    it.window_end = we;
    it.morph = m;
    it.restart = rs;
    return it;
  endfunction

  // field extremes, every morph region edge, restart and window wraps
  task automatic test_directed();
    logic [15:0] morph_edges [12];
    int i;
    morph_edges = '{16'd0, 16'd10000, 16'd21626, 16'd21627, 16'd22282, 16'd22283,
                    16'd43253, 16'd43254, 16'd43908, 16'd43909, 16'd55000, 16'hffff};
    for (i = 0; i < 12; i++)
      send_item(make_item(24'd300000, 16'd0, 16'd0, morph_edges[i], 1'b0));
    send_item(make_item(24'hffffff, 16'd0, 16'd0, 16'd0, 1'b0));
    send_item(make_item(24'hffffff, 16'hffff, 16'hffff, 16'hffff, 1'b0));
    send_item(make_item(24'd0, 16'hffff, 16'd0, 16'd30000, 1'b1));
    send_item(make_item(24'd0, 16'd30000, 16'd0, 16'd30000, 1'b1));
    send_item(make_item(24'd5000000, 16'd40000, 16'd30000, 16'd50000, 1'b0));
    send_item(make_item(24'd5000000, 16'd10000, 16'd60000, 16'd0, 1'b0));
    send_item(make_item(24'd0, 16'd0, 16'hffff, 16'd0, 1'b0));
    send_item(make_item(24'h555555, 16'h5555, 16'haaaa, 16'h5555, 1'b1));
    send_item(make_item(24'haaaaaa, 16'haaaa, 16'h5555, 16'haaaa, 1'b0));
    drain();
  endtask

  // sample rate extremes, zero included, with random items in between
  task automatic test_rate_sweep();
    logic [SrBits-1:0] rates [5];
    int i, j;
    rates = '{18'd1, 18'd192000, 18'd0, 18'h3ffff, 18'd7};
    for (i = 0; i < 5; i++) begin
      write_sample_rate(rates[i]);
      for (j = 0; j < 20; j++) send_item(random_item());
      drain();
    end
    write_sample_rate(SrReset);
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    int i;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (i = 0; i < n; i++) send_item(random_item());
    drain();
  endtask

  // receiver holds off long while items keep coming
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 600;
    for (i = 0; i < 20; i++) send_item(random_item());
    drain();
  endtask

  initial begin
    int i;
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.sample_rate = '0;
    item_ch.valid = 1'b0;
    item_ch.frequency = '0;
    item_ch.window_start = '0;
    item_ch.window_end = '0;
    item_ch.morph = '0;
    item_ch.restart = 1'b0;
    res_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    mismatches = 0;
    failed = 1'b0;
    for (i = 0; i <= QtrN; i++)
      quarter_sine[i] = taylor_sine((64'd421657428 * i) / QtrN);
    model_phase = 0;
    model_rate = SrReset;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_rate_sweep();
    test_random(500, 21, 64);
    write_sample_rate(18'd1000);
    test_random(500, 64, 21);
    write_sample_rate(18'd192000);
    test_random(400, 0, 0);
    test_backpressure();

    if (failed) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end

endmodule
